// ----- rtl/core/gray_image_upscaler_2x_3x_unit_defines.svh -----
// Assertion macros for the gray image upscaler.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef GRAY_IMAGE_UPSCALER_2X_3X_UNIT_DEFINES_SVH
`define GRAY_IMAGE_UPSCALER_2X_3X_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, masked while reset is high.
`define UPX_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("upscaler check failed");

// Next-cycle implication, masked while reset is high.
`define UPX_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("upscaler check failed");

// Next-cycle implication that also holds across reset.
`define UPX_ASSERT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("upscaler reset check failed");

`else

`define UPX_ASSERT_IMP(label, clk, rst, ante, cons)
`define UPX_ASSERT_NXT(label, clk, rst, ante, cons)
`define UPX_ASSERT_RST(label, clk, ante, cons)

`endif

`endif

// ----- rtl/core/upx_pkg.sv -----
package upx_pkg;

  // Image limits and field widths.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int SIZE_W     = 11;
  localparam int COORD_W    = 12;
  localparam int PIX_W      = 8;
  localparam int CMP_W      = (SIZE_W > COL_W + 1) ?
                              ((SIZE_W > ROW_W + 1) ? SIZE_W : ROW_W + 1) :
                              ((COL_W > ROW_W) ? COL_W + 1 : ROW_W + 1);
  localparam int Q_DEPTH    = 2;

  typedef logic [PIX_W-1:0]            pix_t;
  typedef logic [COL_W-1:0]            col_t;
  typedef logic [ROW_W-1:0]            row_t;
  typedef logic [SIZE_W-1:0]           size_t;
  typedef logic [COORD_W-1:0]          coord_t;
  typedef logic [CMP_W-1:0]            cmp_t;
  typedef logic [3:0]                  step_t;
  typedef logic [$clog2(Q_DEPTH)-1:0]  qptr_t;
  typedef logic [$clog2(Q_DEPTH+1)-1:0] qcnt_t;

  // Register indexes of the configuration port.
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SCALE  = 2'd2;

  // Final step of a block at each scale.
  localparam step_t LAST_STEP_S2 = 4'd3;
  localparam step_t LAST_STEP_S3 = 4'd8;

  // Effective configuration after saturation.
  typedef struct packed {
    size_t width;
    size_t height;
    logic  scale3;
  } cfg_t;

  // One block job handed from the front to the back.
  typedef struct packed {
    pix_t   n0;
    pix_t   n1;
    pix_t   n2;
    pix_t   n3;
    coord_t col;
    coord_t row;
    logic   scale3;
    logic   last_frame;
  } job_t;

  // Head of the job queue as seen by the back.
  typedef struct packed {
    job_t job;
    logic empty;
  } qhead_t;

  // Floor of x / 3 for x below 768, by reciprocal multiplication.
  function automatic pix_t div3(input logic [9:0] x);
    logic [20:0] prod;
    prod = 21'(x) * 21'd683;
    return prod[18:11];
  endfunction

  // Interpolated value of one step of a block.
  function automatic pix_t step_value(input logic scale3, input step_t step,
                                      input pix_t n0, input pix_t n1,
                                      input pix_t n2, input pix_t n3);
    logic [9:0]  sum4;
    logic [10:0] six;
    logic [9:0]  num;
    logic        use_div;
    sum4    = 10'(n0) + 10'(n1) + 10'(n2) + 10'(n3);
    six     = '0;
    num     = 10'(n0);
    use_div = 1'b0;
    if (scale3) begin
      case (step)
        4'd1: begin num = 10'({n0, 1'b0}) + 10'(n1); use_div = 1'b1; end
        4'd2: begin num = 10'(n0) + 10'({n1, 1'b0}); use_div = 1'b1; end
        4'd3: begin num = 10'({n0, 1'b0}) + 10'(n2); use_div = 1'b1; end
        4'd4: begin num = 10'(n0) + 10'({n2, 1'b0}); use_div = 1'b1; end
        4'd5: begin
          six = 11'(sum4) + 11'({n0, 1'b0}); num = six[10:1]; use_div = 1'b1;
        end
        4'd6: begin
          six = 11'(sum4) + 11'({n1, 1'b0}); num = six[10:1]; use_div = 1'b1;
        end
        4'd7: begin
          six = 11'(sum4) + 11'({n2, 1'b0}); num = six[10:1]; use_div = 1'b1;
        end
        4'd8: begin
          six = 11'(sum4) + 11'({n3, 1'b0}); num = six[10:1]; use_div = 1'b1;
        end
        default: num = 10'(n0);
      endcase
    end else begin
      case (step)
        4'd1:    num = (10'(n0) + 10'(n1)) >> 1;
        4'd2:    num = (10'(n0) + 10'(n2)) >> 1;
        4'd3:    num = sum4 >> 2;
        default: num = 10'(n0);
      endcase
    end
    return use_div ? div3(num) : num[7:0];
  endfunction

  // Column offset inside the block for each step.
  function automatic logic [1:0] step_dx(input logic scale3, input step_t step);
    logic [1:0] dx;
    dx = 2'd0;
    if (scale3) begin
      case (step)
        4'd1, 4'd5, 4'd7: dx = 2'd1;
        4'd2, 4'd6, 4'd8: dx = 2'd2;
        default:          dx = 2'd0;
      endcase
    end else begin
      case (step)
        4'd1, 4'd3: dx = 2'd1;
        default:    dx = 2'd0;
      endcase
    end
    return dx;
  endfunction

  // Row offset inside the block for each step.
  function automatic logic [1:0] step_dy(input logic scale3, input step_t step);
    logic [1:0] dy;
    dy = 2'd0;
    if (scale3) begin
      case (step)
        4'd3, 4'd5, 4'd6: dy = 2'd1;
        4'd4, 4'd7, 4'd8: dy = 2'd2;
        default:          dy = 2'd0;
      endcase
    end else begin
      case (step)
        4'd2, 4'd3: dy = 2'd1;
        default:    dy = 2'd0;
      endcase
    end
    return dy;
  endfunction

endpackage

// ----- rtl/core/upx_ram.sv -----
// Simple dual-port RAM, one write and one registered read, read-first.
module upx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

// ----- rtl/core/upx_front.sv -----
// Front end: position counters, line buffer and neighbor registers.
// It turns each pixel with a full neighborhood into a block job.
module upx_front (
  input  logic            clk,
  input  logic            rst,
  input  upx_pkg::cfg_t   cfg,
  input  logic            in_valid,
  output logic            in_stall,
  input  upx_pkg::pix_t   pixel,
  input  logic            frame_start,
  input  logic            q_full,
  output logic            push,
  output upx_pkg::job_t   push_job
);

  upx_pkg::col_t col_count;
  upx_pkg::row_t row_count;
  upx_pkg::col_t cur_col;
  upx_pkg::row_t cur_row;
  upx_pkg::cmp_t col_inc;
  upx_pkg::cmp_t row_inc;
  logic          in_go;

  logic          a_valid;
  upx_pkg::pix_t a_pixel;
  upx_pkg::col_t a_col;
  upx_pkg::row_t a_row;
  logic          a_emit;
  logic          a_go;

  upx_pkg::pix_t up_pixel;
  upx_pkg::pix_t left_pixel;
  upx_pkg::pix_t upper_left_pixel;
  upx_pkg::coord_t col_m1;
  upx_pkg::coord_t row_m1;

  // Accept a pixel unless the held stage cannot move on.
  assign in_stall = a_valid && !a_go;
  assign in_go    = in_valid && !in_stall;

  // Frame start restarts the position before the pixel is taken.
  assign cur_col = frame_start ? '0 : col_count;
  assign cur_row = frame_start ? '0 : row_count;
  assign col_inc = upx_pkg::cmp_t'(cur_col) + upx_pkg::cmp_t'(1);
  assign row_inc = upx_pkg::cmp_t'(cur_row) + upx_pkg::cmp_t'(1);

  // Position counters wrap at the row end and at the frame end.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (in_go) begin
      if (col_inc >= upx_pkg::cmp_t'(cfg.width)) begin
        col_count <= '0;
        if (row_inc >= upx_pkg::cmp_t'(cfg.height)) begin
          row_count <= '0;
        end else begin
          row_count <= row_inc[upx_pkg::ROW_W-1:0];
        end
      end else begin
        col_count <= col_inc[upx_pkg::COL_W-1:0];
        row_count <= cur_row;
      end
    end
  end

  // Line buffer: read the pixel above and store the new one in one transfer.
  upx_ram #(
    .WIDTH (upx_pkg::PIX_W),
    .DEPTH (upx_pkg::MAX_WIDTH)
  ) u_line (
    .clk     (clk),
    .wr_en   (in_go),
    .wr_addr (cur_col),
    .wr_data (pixel),
    .rd_en   (in_go),
    .rd_addr (cur_col),
    .rd_data (up_pixel)
  );

  // Stage that waits for the line buffer read.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_go) begin
      a_valid <= 1'b1;
    end else if (a_go) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      a_pixel <= pixel;
      a_col   <= cur_col;
      a_row   <= cur_row;
    end
  end

  // Only pixels past the first row and column make a block.
  assign a_emit = (a_col != '0) && (a_row != '0);
  assign a_go   = !a_emit || !q_full;
  assign push   = a_valid && a_emit && !q_full;

  // Neighbor registers follow every pixel that leaves the stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      upper_left_pixel <= '0;
    end else if (a_valid && a_go) begin
      left_pixel       <= a_pixel;
      upper_left_pixel <= up_pixel;
    end
  end

  // Block origin is the previous source position times the scale.
  assign col_m1 = upx_pkg::coord_t'(a_col) - upx_pkg::coord_t'(1);
  assign row_m1 = upx_pkg::coord_t'(a_row) - upx_pkg::coord_t'(1);

  always_comb begin
    push_job.n0     = upper_left_pixel;
    push_job.n1     = up_pixel;
    push_job.n2     = left_pixel;
    push_job.n3     = a_pixel;
    push_job.scale3 = cfg.scale3;
    push_job.col    = cfg.scale3 ? (col_m1 << 1) + col_m1 : col_m1 << 1;
    push_job.row    = cfg.scale3 ? (row_m1 << 1) + row_m1 : row_m1 << 1;
    push_job.last_frame =
      (upx_pkg::cmp_t'(a_col) + upx_pkg::cmp_t'(1) == upx_pkg::cmp_t'(cfg.width)) &&
      (upx_pkg::cmp_t'(a_row) + upx_pkg::cmp_t'(1) == upx_pkg::cmp_t'(cfg.height));
  end

endmodule

// ----- rtl/core/upx_queue.sv -----
// Short job queue between the front and the back.
module upx_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  upx_pkg::job_t    push_job,
  output logic             full,
  input  logic             pop,
  output upx_pkg::qhead_t  head,
  output upx_pkg::qcnt_t   count
);

  upx_pkg::job_t  entries [upx_pkg::Q_DEPTH];
  upx_pkg::qptr_t wr_ptr;
  upx_pkg::qptr_t rd_ptr;

  assign full       = (count == upx_pkg::qcnt_t'(upx_pkg::Q_DEPTH));
  assign head.empty = (count == '0);
  assign head.job   = entries[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + upx_pkg::qptr_t'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + upx_pkg::qptr_t'(1);
      end
      if (push && !pop) begin
        count <= count + upx_pkg::qcnt_t'(1);
      end else if (pop && !push) begin
        count <= count - upx_pkg::qcnt_t'(1);
      end
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

// ----- rtl/core/upx_back.sv -----
// Back end: walks each block job one value per cycle into the output register while the output is not stalled.
module upx_back (
  input  logic              clk,
  input  logic              rst,
  input  upx_pkg::qhead_t   head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_stall,
  output upx_pkg::pix_t     out_value,
  output upx_pkg::coord_t   out_col,
  output upx_pkg::coord_t   out_row,
  output logic              last_of_block,
  output logic              last_of_frame
);

  upx_pkg::step_t step;
  logic           last_step;
  logic           produce;

  assign last_step = head.job.scale3 ? (step == upx_pkg::LAST_STEP_S3)
                                     : (step == upx_pkg::LAST_STEP_S2);
  assign produce   = !head.empty && (!out_valid || !out_stall);
  assign pop       = produce && last_step;

  // Step counter within the current block.
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (produce) begin
      step <= last_step ? '0 : step + upx_pkg::step_t'(1);
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (produce) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload, loaded on every new value.
  always_ff @(posedge clk) begin
    if (produce) begin
      out_value     <= upx_pkg::step_value(head.job.scale3, step, head.job.n0,
                                           head.job.n1, head.job.n2, head.job.n3);
      out_col       <= head.job.col +
                       upx_pkg::coord_t'(upx_pkg::step_dx(head.job.scale3, step));
      out_row       <= head.job.row +
                       upx_pkg::coord_t'(upx_pkg::step_dy(head.job.scale3, step));
      last_of_block <= last_step;
      last_of_frame <= last_step && head.job.last_frame;
    end
  end

endmodule

// ----- rtl/core/gray_image_upscaler_2x_3x_unit.sv -----
// The first value of a block passes the read stage, the job queue and the output
// register. Throughput: one output value per cycle from the block sequencer while
// the output is not stalled; a block has 4 values at scale 2 and 9 at scale 3, and
// first row or column pixels make no block. The line buffer is a 1024-entry RAM.
// Reset (synchronous, active high) clears counters, neighbors, queue and output;
// the line buffer is not cleared and sizes return to 1024 by 1024 at scale 2.
`include "gray_image_upscaler_2x_3x_unit_defines.svh"

module gray_image_upscaler_2x_3x_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_en,
  input  logic [1:0]                 cfg_index,
  input  logic [upx_pkg::SIZE_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 pixel,
  input  logic                       frame_start,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 out_value,
  output logic [11:0]                out_col,
  output logic [11:0]                out_row,
  output logic                       last_of_block,
  output logic                       last_of_frame
);

  upx_pkg::size_t  image_width;
  upx_pkg::size_t  image_height;
  logic [1:0]      scale_factor;
  upx_pkg::cfg_t   cfg;

  logic            q_full;
  logic            push;
  upx_pkg::job_t   push_job;
  logic            pop;
  upx_pkg::qhead_t head;
  upx_pkg::qcnt_t  q_count;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= upx_pkg::size_t'(upx_pkg::MAX_WIDTH);
      image_height <= upx_pkg::size_t'(upx_pkg::MAX_HEIGHT);
      scale_factor <= 2'd2;
    end else if (cfg_en) begin
      case (cfg_index)
        upx_pkg::CFG_WIDTH:  image_width  <= cfg_data;
        upx_pkg::CFG_HEIGHT: image_height <= cfg_data;
        upx_pkg::CFG_SCALE:  scale_factor <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Saturate sizes and decode the scale.
  always_comb begin
    if (image_width < upx_pkg::size_t'(3)) begin
      cfg.width = upx_pkg::size_t'(3);
    end else if (image_width > upx_pkg::size_t'(upx_pkg::MAX_WIDTH)) begin
      cfg.width = upx_pkg::size_t'(upx_pkg::MAX_WIDTH);
    end else begin
      cfg.width = image_width;
    end
    if (image_height < upx_pkg::size_t'(3)) begin
      cfg.height = upx_pkg::size_t'(3);
    end else if (image_height > upx_pkg::size_t'(upx_pkg::MAX_HEIGHT)) begin
      cfg.height = upx_pkg::size_t'(upx_pkg::MAX_HEIGHT);
    end else begin
      cfg.height = image_height;
    end
    cfg.scale3 = (scale_factor == 2'd3);
  end

  upx_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel       (pixel),
    .frame_start (frame_start),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job)
  );

  upx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .count    (q_count)
  );

  upx_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_col       (out_col),
    .out_row       (out_row),
    .last_of_block (last_of_block),
    .last_of_frame (last_of_frame)
  );

  // The frame end marker only sits on the closing value of a block.
  `UPX_ASSERT_IMP(a_frame_on_block_end, clk, rst, out_valid && last_of_frame, last_of_block)

  // Once a block has started, its values follow without a gap.
  `UPX_ASSERT_NXT(a_block_no_gap, clk, rst, out_valid && !out_stall && !last_of_block, out_valid)

  // The queue is never pushed while it holds its full depth of jobs.
  `UPX_ASSERT_IMP(a_queue_bound, clk, rst, push, q_count != upx_pkg::qcnt_t'(upx_pkg::Q_DEPTH))

  // Reset empties the output register.
  `UPX_ASSERT_RST(a_reset_clears_out, clk, rst, !out_valid)

endmodule
